@@ src/sttc_pkg.sv @@
`timescale 1ns / 1ps
package sttc_pkg;

	localparam int unsigned MAX_ENTRIES_D = 128;
	localparam int unsigned NUM_AGENTS_D  = 16;
	localparam int unsigned KEY_BITS_D    = 16;

	localparam logic [31:0] TIME_CLEARED  = 32'hffff_f600;
	localparam logic [15:0] COOLDOWN_RST  = 16'd2560;
	localparam logic [2:0]  EXCL_RST      = 3'd2;

	localparam logic [2:0] MODE_CLEAR   = 3'd0;
	localparam logic [2:0] MODE_INSERT  = 3'd1;
	localparam logic [2:0] MODE_CHECK   = 3'd2;
	localparam logic [2:0] MODE_CLAIM   = 3'd3;
	localparam logic [2:0] MODE_CLOSEST = 3'd4;

	localparam logic REG_COOLDOWN = 1'b0;
	localparam logic REG_EXCL     = 1'b1;

	typedef struct packed {
		logic        found;
		logic [6:0]  idx;
		logic        recent;
		logic [15:0] key;
		logic [2:0]  kind;
		logic        full;
	} sttc_res_t;

	function automatic logic rested(input logic [31:0] now_v, input logic [31:0] then_v,
			input logic [15:0] cool);
		logic [31:0] d;
		d = now_v - then_v;
		return !d[31] && (d > {16'b0, cool});
	endfunction

endpackage

@@ src/sorted_trigger_table_cursor_search.sv @@
`timescale 1ns / 1ps
// Per word: claim reads one entry, clear sweeps every entry, insert shifts larger keys up from
// the end, check walks from the agent's cursor, closest scans from index 0; one RAM read per entry.
// Throughput: one word at a time; ready is low until the result is loaded to the output.
// Reset: registers to 2560 and 2, table emptied, then a sweep of all MAX_ENTRIES entries
// restores every claim time before the first word is taken.
module sorted_trigger_table_cursor_search
	import sttc_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_D,
	parameter int unsigned NUM_AGENTS  = NUM_AGENTS_D,
	parameter int unsigned KEY_BITS    = KEY_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  mode,
	input  logic [3:0]  agent,
	input  logic [15:0] position_key,
	input  logic [2:0]  kind,
	input  logic [6:0]  entry_index,
	input  logic signed [1:0]  direction,
	input  logic signed [31:0] now,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        found,
	output logic [6:0]  hit_index,
	output logic        recently_used,
	output logic [15:0] hit_key,
	output logic [2:0]  hit_kind,
	output logic        table_full
);
	logic [15:0] cool_q;
	logic [2:0]  excl_q;
	logic        ovalid_q;
	sttc_res_t   out_q, res;
	logic        idle, done, res_free, start;

	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == REG_EXCL) ? {29'b0, excl_q} : {16'b0, cool_q};
	assign item_ready = idle;
	assign start      = item_valid && idle;
	assign res_free   = !ovalid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_q <= COOLDOWN_RST;
			excl_q <= EXCL_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_COOLDOWN) cool_q <= pwdata[15:0];
			else excl_q <= pwdata[2:0];
		end
	end

	sttc_engine #(
		.MAX_ENTRIES(MAX_ENTRIES), .NUM_AGENTS(NUM_AGENTS), .KEY_BITS(KEY_BITS)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .mode(mode), .agent(agent),
		.position_key(position_key), .kind(kind), .entry_index(entry_index),
		.direction(direction), .now(now), .cooldown(cool_q), .excl(excl_q),
		.res_free(res_free), .idle(idle), .done(done), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (done) begin
			ovalid_q <= 1'b1;
		end else if (res_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) out_q <= res;
	end

	assign res_valid     = ovalid_q;
	assign found         = out_q.found;
	assign hit_index     = out_q.idx;
	assign recently_used = out_q.recent;
	assign hit_key       = out_q.key;
	assign hit_kind      = out_q.kind;
	assign table_full    = out_q.full;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("engine still idle after taking a word");
	a_done_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!res_valid || res_ready))
		else $error("result loaded over a pending word");
	a_valid_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> res_valid)
		else $error("result lost");
`endif
endmodule

@@ src/sttc_ram.sv @@
`timescale 1ns / 1ps
module sttc_ram #(
	parameter int unsigned AW = 7,
	parameter int unsigned DW = 51
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ src/sttc_engine.sv @@
`timescale 1ns / 1ps
module sttc_engine
	import sttc_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_D,
	parameter int unsigned NUM_AGENTS  = NUM_AGENTS_D,
	parameter int unsigned KEY_BITS    = KEY_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  mode,
	input  logic [3:0]  agent,
	input  logic [15:0] position_key,
	input  logic [2:0]  kind,
	input  logic [6:0]  entry_index,
	input  logic [1:0]  direction,
	input  logic [31:0] now,
	input  logic [15:0] cooldown,
	input  logic [2:0]  excl,
	input  logic        res_free,
	output logic        idle,
	output logic        done,
	output sttc_res_t   res
);
	localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned IW  = $clog2(MAX_ENTRIES);
	localparam int unsigned AGW = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
	localparam int unsigned DW  = 32 + 3 + KEY_BITS;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_SWEEP   = 12'b0000_0000_0010,
		S_INS_RD  = 12'b0000_0000_0100,
		S_INS_CMP = 12'b0000_0000_1000,
		S_INS_WR  = 12'b0000_0001_0000,
		S_CHK_RD  = 12'b0000_0010_0000,
		S_CHK_CMP = 12'b0000_0100_0000,
		S_CLM_RD  = 12'b0000_1000_0000,
		S_CLM_CMP = 12'b0001_0000_0000,
		S_CLS_RD  = 12'b0010_0000_0000,
		S_CLS_CMP = 12'b0100_0000_0000,
		S_DONE    = 12'b1000_0000_0000
	} state_t;

	state_t              st_q;
	logic                emit_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       cur_q [NUM_AGENTS];
	logic                up_q, first_q, hf_q, hp_q;
	logic [CW-1:0]       first_idx_q, prev_idx_q;
	logic [KEY_BITS-1:0] first_key_q, prev_key_q;
	logic [2:0]          kind_q;
	logic [AGW-1:0]      agi_q;
	logic [KEY_BITS-1:0] key_q;
	logic [6:0]          eidx_q;
	logic                fwd_q, back_q;
	logic [31:0]         now_q;
	sttc_res_t           res_q;

	logic                we;
	logic [IW-1:0]       waddr, raddr;
	logic [DW-1:0]       wdata, rd;
	logic [KEY_BITS-1:0] rkey, key_in;
	logic [2:0]          rkind;
	logic [31:0]         rtime, ctime;
	logic [AGW-1:0]      agm;
	logic [IW-1:0]       cstart;
	logic                lt, gt, upe, mv, m, eidx_lt_n, eidx_in;
	logic [CW-1:0]       last;

	function automatic logic [AGW-1:0] agent_fold(input logic [3:0] a);
		logic [AGW-1:0] r;
		logic [AGW-1:0] f;
		r = '0;
		f = '0;
		for (int i = 0; i < 16; i++) begin
			if (4'(i) == a) f = r;
			if (32'(r) == NUM_AGENTS - 1) r = '0;
			else r = r + 1'b1;
		end
		return f;
	endfunction

	sttc_ram #(.AW(IW), .DW(DW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
	);

	assign rkey   = rd[KEY_BITS-1:0];
	assign rkind  = rd[KEY_BITS+2:KEY_BITS];
	assign rtime  = rd[DW-1 -: 32];
	assign key_in = KEY_BITS'(position_key);
	assign agm    = agent_fold(agent);
	assign last   = cnt_q - CW'(1);
	assign cstart = (CW'(cur_q[agm]) >= cnt_q) ? IW'(last) : cur_q[agm];
	assign lt     = rkey < key_q;
	assign gt     = key_q < rkey;
	assign upe    = first_q ? lt : up_q;
	assign mv     = upe ? (lt && ptr_q != last) : (gt && ptr_q != '0);
	assign m      = rkind == kind_q;
	assign eidx_in   = 32'(eidx_q) < MAX_ENTRIES;
	assign eidx_lt_n = 32'(eidx_q) < 32'(cnt_q);
	assign ctime  = eidx_in ? rtime : TIME_CLEARED;

	always_comb begin
		unique case (st_q)
			S_INS_RD: raddr = IW'(ptr_q - CW'(1));
			S_CLM_RD: raddr = IW'(eidx_q);
			default:  raddr = IW'(ptr_q);
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = IW'(ptr_q);
		wdata = rd;
		unique case (st_q)
			S_SWEEP: begin
				we    = 1'b1;
				wdata = {TIME_CLEARED, 3'b0, {KEY_BITS{1'b0}}};
			end
			S_INS_CMP: begin
				we = gt;
			end
			S_INS_WR: begin
				we    = 1'b1;
				wdata = {TIME_CLEARED, kind_q, key_q};
			end
			S_CLM_CMP: begin
				we    = eidx_lt_n;
				waddr = IW'(eidx_q);
				wdata = {now_q, rkind, rkey};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_SWEEP;
			emit_q  <= 1'b0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			up_q    <= 1'b0;
			first_q <= 1'b0;
			hf_q    <= 1'b0;
			hp_q    <= 1'b0;
			res_q   <= '0;
			for (int i = 0; i < NUM_AGENTS; i++) cur_q[i] <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						res_q  <= '0;
						agi_q  <= agm;
						key_q  <= key_in;
						kind_q <= kind;
						eidx_q <= entry_index;
						fwd_q  <= direction == 2'b01;
						back_q <= direction[1];
						now_q  <= now;
						case (mode)
							MODE_CLEAR: begin
								cnt_q  <= '0;
								ptr_q  <= '0;
								emit_q <= 1'b1;
								for (int i = 0; i < NUM_AGENTS; i++) cur_q[i] <= '0;
								st_q   <= S_SWEEP;
							end
							MODE_INSERT: begin
								if (32'(cnt_q) >= MAX_ENTRIES) begin
									res_q.full <= 1'b1;
									st_q       <= S_DONE;
								end else begin
									ptr_q <= cnt_q;
									st_q  <= (cnt_q == '0) ? S_INS_WR : S_INS_RD;
								end
							end
							MODE_CHECK: begin
								ptr_q   <= CW'(cstart);
								first_q <= 1'b1;
								st_q    <= (cnt_q == '0) ? S_DONE : S_CHK_RD;
							end
							MODE_CLAIM: begin
								st_q <= S_CLM_RD;
							end
							MODE_CLOSEST: begin
								ptr_q <= '0;
								hf_q  <= 1'b0;
								hp_q  <= 1'b0;
								st_q  <= (cnt_q == '0) ? S_DONE : S_CLS_RD;
							end
							default: begin
								st_q <= S_DONE;
							end
						endcase
					end
				end
				S_SWEEP: begin
					ptr_q <= ptr_q + CW'(1);
					if (32'(ptr_q) == MAX_ENTRIES - 1) begin
						st_q   <= emit_q ? S_DONE : S_IDLE;
						emit_q <= 1'b0;
					end
				end
				S_INS_RD: st_q <= S_INS_CMP;
				S_INS_CMP: begin
					if (gt) begin
						ptr_q <= ptr_q - CW'(1);
						st_q  <= (ptr_q == CW'(1)) ? S_INS_WR : S_INS_RD;
					end else begin
						st_q <= S_INS_WR;
					end
				end
				S_INS_WR: begin
					cnt_q       <= cnt_q + CW'(1);
					res_q.found <= 1'b1;
					res_q.idx   <= 7'(ptr_q);
					res_q.key   <= 16'(key_q);
					res_q.kind  <= kind_q;
					st_q        <= S_DONE;
				end
				S_CHK_RD: st_q <= S_CHK_CMP;
				S_CHK_CMP: begin
					first_q <= 1'b0;
					up_q    <= upe;
					if (mv) begin
						ptr_q <= upe ? ptr_q + CW'(1) : ptr_q - CW'(1);
						st_q  <= S_CHK_RD;
					end else begin
						cur_q[agi_q] <= IW'(ptr_q);
						if (rkey == key_q && rested(now_q, rtime, cooldown) && rkind != excl)
								begin
							res_q.found <= 1'b1;
							res_q.idx   <= 7'(ptr_q);
							res_q.key   <= 16'(rkey);
							res_q.kind  <= rkind;
						end
						st_q <= S_DONE;
					end
				end
				S_CLM_RD: st_q <= S_CLM_CMP;
				S_CLM_CMP: begin
					res_q.recent <= !rested(now_q, ctime, cooldown);
					res_q.idx    <= eidx_q;
					if (eidx_lt_n) begin
						res_q.found <= 1'b1;
						res_q.key   <= 16'(rkey);
						res_q.kind  <= rkind;
					end
					st_q <= S_DONE;
				end
				S_CLS_RD: st_q <= S_CLS_CMP;
				S_CLS_CMP: begin
					res_q.kind <= kind_q;
					if (m && (rkey == key_q || (gt && fwd_q))) begin
						res_q.found <= 1'b1;
						res_q.idx   <= 7'(ptr_q);
						res_q.key   <= 16'(rkey);
						st_q        <= S_DONE;
					end else if (m && gt && back_q && hp_q) begin
						res_q.found <= 1'b1;
						res_q.idx   <= 7'(prev_idx_q);
						res_q.key   <= 16'(prev_key_q);
						st_q        <= S_DONE;
					end else begin
						if (m) begin
							if (!hf_q) begin
								hf_q        <= 1'b1;
								first_idx_q <= ptr_q;
								first_key_q <= rkey;
							end
							hp_q       <= 1'b1;
							prev_idx_q <= ptr_q;
							prev_key_q <= rkey;
						end
						if (ptr_q == last) begin
							if (back_q && (m || hp_q)) begin
								res_q.found <= 1'b1;
								res_q.idx   <= m ? 7'(ptr_q) : 7'(prev_idx_q);
								res_q.key   <= m ? 16'(rkey) : 16'(prev_key_q);
							end else if (fwd_q && (m || hf_q)) begin
								res_q.found <= 1'b1;
								res_q.idx   <= hf_q ? 7'(first_idx_q) : 7'(ptr_q);
								res_q.key   <= hf_q ? 16'(first_key_q) : 16'(rkey);
							end else begin
								res_q.kind <= '0;
							end
							st_q <= S_DONE;
						end else begin
							ptr_q <= ptr_q + CW'(1);
							st_q  <= S_CLS_RD;
						end
					end
				end
				S_DONE: begin
					if (res_free) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign idle = st_q == S_IDLE;
	assign done = (st_q == S_DONE) && res_free;
	assign res  = res_q;
endmodule
